// File: rtl/crfa_pkg.sv
// ============================================================================
// crfa_pkg - shared types and constants of the report filter
// Field widths, register indexes, queue entry layout and the neutral report.
// ============================================================================
`default_nettype none

package crfa_pkg;

  localparam int NUM_CONTROLLERS = 4;

  localparam int CTRL_W   = 2;
  localparam int SEQ_W    = 32;
  localparam int BTN_W    = 16;
  localparam int HAT_W    = 4;
  localparam int AXIS_W   = 8;
  localparam int PERIOD_W = 10;
  localparam int WDOG_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  // Sequence gap beyond which an old packet is taken as a restart
  localparam logic [SEQ_W-1:0] SEQ_JUMP_LIMIT = 32'd100;
  // Buttons of the last sent report after reset, so every controller reports once
  localparam logic [BTN_W-1:0] SENT_RESET_BUTTONS = 16'h00FF;

  localparam logic [PERIOD_W-1:0] AUTOFIRE_PERIOD_RST = 10'd50;
  localparam logic [WDOG_W-1:0]   WATCHDOG_TICKS_RST  = 16'd100;
  localparam logic [HAT_W-1:0]    NEUTRAL_HAT_RST     = 4'd0;
  localparam logic [AXIS_W-1:0]   NEUTRAL_STICK_RST   = 8'd0;

  // Request kinds
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTOFIRE_PERIOD = 2'd0,
    REG_WATCHDOG_TICKS  = 2'd1,
    REG_NEUTRAL_HAT     = 2'd2,
    REG_NEUTRAL_STICK   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] autofire_period;
    logic [WDOG_W-1:0]   watchdog_ticks;
    logic [HAT_W-1:0]    neutral_hat;
    logic [AXIS_W-1:0]   neutral_stick;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0]  buttons;
    logic [HAT_W-1:0]  hat;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
  } report_t;

  typedef struct packed {
    logic              req_type;
    logic [CTRL_W-1:0] controller;
    logic [SEQ_W-1:0]  seq;
    logic              reset_flag;
    logic              autofire_flag;
    logic [BTN_W-1:0]  fire_mask;
    logic [BTN_W-1:0]  buttons;
    logic [HAT_W-1:0]  hat;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
  } in_item_t;

  typedef struct packed {
    logic [CTRL_W-1:0] out_controller;
    logic [BTN_W-1:0]  out_buttons;
    logic [HAT_W-1:0]  out_hat;
    logic [AXIS_W-1:0] out_left_x;
    logic [AXIS_W-1:0] out_left_y;
    logic [AXIS_W-1:0] out_right_x;
    logic [AXIS_W-1:0] out_right_y;
    logic              last_of_tick;
  } out_item_t;

  // Classified request passed from the front to the back
  typedef struct packed {
    logic              tick;
    logic [CTRL_W-1:0] controller;
    logic              reset_flag;
    logic [BTN_W-1:0]  mask;
    report_t           report;
  } qop_t;

  function automatic report_t neutral_report(cfg_t cfg);
    report_t r;
    r.buttons = '0;
    r.hat     = cfg.neutral_hat;
    r.left_x  = cfg.neutral_stick;
    r.left_y  = cfg.neutral_stick;
    r.right_x = cfg.neutral_stick;
    r.right_y = cfg.neutral_stick;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crfa_stream_if.sv
// ============================================================================
// crfa_stream_if - valid/ready channel
// Carries one request of the given payload type per handshake.
// ============================================================================
`default_nettype none

interface crfa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/crfa_front.sv
// ============================================================================
// crfa_front - request intake and sequence filter
// Accepts requests, drops stale or foreign packets and queues the rest.
// ============================================================================
`default_nettype none

module crfa_front #(
  parameter int NumControllers = crfa_pkg::NUM_CONTROLLERS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  crfa_stream_if.sink   in_i,
  crfa_stream_if.source op_o
);

  localparam int IdxW = (NumControllers > 1) ? $clog2(NumControllers) : 1;

  logic                          awaiting_q [NumControllers];
  logic [crfa_pkg::SEQ_W-1:0]    expect_q   [NumControllers];

  crfa_pkg::in_item_t            item;
  crfa_pkg::qop_t                op;
  logic [IdxW-1:0]               idx;
  logic [crfa_pkg::SEQ_W-1:0]    exp_seq;
  logic                          is_tick;
  logic                          in_range;
  logic                          older;
  logic                          jump;
  logic                          keep;
  logic                          take_pkt;

  // Classify the request on offer
  always_comb begin
    item     = in_i.data;
    idx      = IdxW'(item.controller);
    is_tick  = (item.req_type == crfa_pkg::REQ_TICK);
    in_range = (int'(item.controller) < NumControllers);
    exp_seq  = expect_q[idx];
    older    = (item.seq < exp_seq);
    jump     = older && ((exp_seq - item.seq) > crfa_pkg::SEQ_JUMP_LIMIT);
    keep     = awaiting_q[idx] || !older || item.reset_flag || jump;
    take_pkt = !is_tick && in_range && keep;

    op.tick       = is_tick;
    op.controller = item.controller;
    op.reset_flag = item.reset_flag;
    op.mask       = item.autofire_flag ? item.fire_mask : '0;
    op.report.buttons = item.buttons;
    op.report.hat     = item.hat;
    op.report.left_x  = item.left_x;
    op.report.left_y  = item.left_y;
    op.report.right_x = item.right_x;
    op.report.right_y = item.right_y;
  end

  // Queue ticks and kept packets; dropped packets are taken and discarded
  assign op_o.valid = in_i.valid && (is_tick || take_pkt);
  assign op_o.data  = op;
  assign in_i.ready = op_o.ready;

  // Advance the expected sequence of a kept packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumControllers; i++) begin
        awaiting_q[i] <= 1'b1;
        expect_q[i]   <= '0;
      end
    end else if (in_i.valid && in_i.ready && take_pkt) begin
      awaiting_q[idx] <= 1'b0;
      expect_q[idx]   <= item.seq + 32'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/crfa_queue.sv
// ============================================================================
// crfa_queue - short request queue
// Decouples the front from the back so that either may stall alone.
// ============================================================================
`default_nettype none

module crfa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  crfa_stream_if.sink   push_i,
  crfa_stream_if.source pop_o
);

  localparam int Depth = crfa_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  crfa_pkg::qop_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign push_i.ready = (count_q != CntW'(Depth));
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.data   = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && push_i.ready;
  assign do_pop  = pop_o.valid && pop_o.ready;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/crfa_back.sv
// ============================================================================
// crfa_back - report state, watchdog and autofire
// Applies queued packets and walks the controllers on each tick.
// ============================================================================
`default_nettype none

module crfa_back #(
  parameter int NumControllers = crfa_pkg::NUM_CONTROLLERS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crfa_pkg::cfg_t cfg_i,
  crfa_stream_if.sink    op_i,
  crfa_stream_if.source  out_o
);

  localparam int IdxW  = (NumControllers > 1) ? $clog2(NumControllers) : 1;
  localparam int RestW = $bits(crfa_pkg::report_t) - crfa_pkg::BTN_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [IdxW-1:0]                 idx_q, idx_d;
  logic                            pend_valid_q, pend_valid_d;
  crfa_pkg::out_item_t             pend_q;
  logic                            out_valid_q, out_valid_d;
  crfa_pkg::out_item_t             out_q;

  crfa_pkg::report_t               cur_q    [NumControllers];
  crfa_pkg::report_t               sent_q   [NumControllers];
  logic [crfa_pkg::BTN_W-1:0]      mask_q   [NumControllers];
  logic [crfa_pkg::PERIOD_W-1:0]   cnt_q    [NumControllers];
  logic [crfa_pkg::BTN_W-1:0]      phase_q  [NumControllers];
  logic [crfa_pkg::WDOG_W-1:0]     sil_q    [NumControllers];
  logic                            armed_q  [NumControllers];

  crfa_pkg::report_t               neutral;
  crfa_pkg::qop_t                  op;
  logic [IdxW-1:0]                 op_idx;
  logic                            pop;
  logic [crfa_pkg::PERIOD_W-1:0]   period_eff;
  logic [crfa_pkg::WDOG_W-1:0]     wdog_eff;

  logic [crfa_pkg::WDOG_W-1:0]     sil_inc;
  logic                            wd_fire;
  crfa_pkg::report_t               rep;
  crfa_pkg::report_t               rep_out;
  logic [crfa_pkg::BTN_W-1:0]      msk;
  logic [crfa_pkg::PERIOD_W-1:0]   cnt_inc;
  logic [crfa_pkg::PERIOD_W-1:0]   cnt_n;
  logic [crfa_pkg::BTN_W-1:0]      phase_n;
  logic                            changed;
  logic                            last_idx;
  logic                            out_free;
  logic                            step;
  crfa_pkg::out_item_t             new_item;
  logic                            out_load;
  crfa_pkg::out_item_t             out_load_item;

  assign neutral    = crfa_pkg::neutral_report(cfg_i);
  assign period_eff = (cfg_i.autofire_period == '0) ? crfa_pkg::PERIOD_W'(1)
                                                    : cfg_i.autofire_period;
  assign wdog_eff   = (cfg_i.watchdog_ticks == '0) ? crfa_pkg::WDOG_W'(1)
                                                   : cfg_i.watchdog_ticks;

  assign op          = op_i.data;
  assign op_idx      = IdxW'(op.controller);
  assign op_i.ready  = (state_q == ST_IDLE);
  assign pop         = op_i.valid && op_i.ready;

  // Evaluate the controller under the walk pointer
  always_comb begin
    sil_inc = (sil_q[idx_q] == '1) ? sil_q[idx_q] : sil_q[idx_q] + crfa_pkg::WDOG_W'(1);
    wd_fire = armed_q[idx_q] && (sil_inc >= wdog_eff);
    rep     = wd_fire ? neutral : cur_q[idx_q];
    msk     = wd_fire ? '0 : mask_q[idx_q];
    cnt_inc = cnt_q[idx_q] + crfa_pkg::PERIOD_W'(1);
    rep_out = rep;
    if (msk != '0) begin
      if (cnt_inc >= period_eff) begin
        cnt_n   = '0;
        phase_n = phase_q[idx_q] ^ msk;
      end else begin
        cnt_n   = cnt_inc;
        phase_n = phase_q[idx_q];
      end
      rep_out.buttons = (rep.buttons & ~msk) | (phase_n & msk);
    end else begin
      cnt_n   = '0;
      phase_n = '0;
    end
    changed  = (rep_out != sent_q[idx_q]);
    last_idx = (idx_q == IdxW'(NumControllers - 1));

    new_item.out_controller = crfa_pkg::CTRL_W'(idx_q);
    new_item.out_buttons    = rep_out.buttons;
    new_item.out_hat        = rep_out.hat;
    new_item.out_left_x     = rep_out.left_x;
    new_item.out_left_y     = rep_out.left_y;
    new_item.out_right_x    = rep_out.right_x;
    new_item.out_right_y    = rep_out.right_y;
    new_item.last_of_tick   = 1'b0;
  end

  // A change found while one is held waits for the output slot
  assign out_free = !out_valid_q || out_o.ready;
  assign step     = (state_q == ST_WALK) && (!(changed && pend_valid_q) || out_free);

  // Sequence the tick walk and release held results
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    pend_valid_d  = pend_valid_q;
    out_load      = 1'b0;
    out_load_item = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && op.tick) begin
          state_d = ST_WALK;
          idx_d   = '0;
        end
      end
      ST_WALK: begin
        if (step) begin
          if (changed) begin
            pend_valid_d = 1'b1;
            out_load     = pend_valid_q;
          end
          if (last_idx) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load                   = 1'b1;
          out_load_item.last_of_tick = 1'b1;
          pend_valid_d               = 1'b0;
          state_d                    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the latest change and the result on offer
  always_ff @(posedge clk_i) begin
    if (step && changed) begin
      pend_q <= new_item;
    end
    if (out_load) begin
      out_q <= out_load_item;
    end
  end

  // Update controller state from packets and tick steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumControllers; i++) begin
        cur_q[i]   <= '0;
        sent_q[i]  <= {crfa_pkg::SENT_RESET_BUTTONS, {RestW{1'b0}}};
        mask_q[i]  <= '0;
        cnt_q[i]   <= '0;
        phase_q[i] <= '0;
        sil_q[i]   <= '0;
        armed_q[i] <= 1'b0;
      end
    end else if (pop && !op.tick) begin
      cur_q[op_idx]   <= op.reset_flag ? neutral : op.report;
      mask_q[op_idx]  <= op.reset_flag ? '0 : op.mask;
      sil_q[op_idx]   <= '0;
      armed_q[op_idx] <= 1'b1;
    end else if (step) begin
      cur_q[idx_q]   <= rep;
      mask_q[idx_q]  <= msk;
      cnt_q[idx_q]   <= cnt_n;
      phase_q[idx_q] <= phase_n;
      if (armed_q[idx_q]) begin
        sil_q[idx_q]   <= wd_fire ? '0 : sil_inc;
        armed_q[idx_q] <= !wd_fire;
      end
      if (changed) begin
        sent_q[idx_q] <= rep_out;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// File: rtl/controller_report_filter_autofire.sv
// ============================================================================
// controller_report_filter_autofire - gamepad report filter
// Per-controller report store with sequence filter, watchdog and autofire.
// ============================================================================
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   cfg      | in  | cfg_we_i      | cfg_idx_i register, cfg_data_i value
//   in_i     | in  | valid / ready | crfa_pkg::in_item_t (packet or tick)
//   out_o    | out | valid / ready | crfa_pkg::out_item_t (changed report)
//
// A packet passes the front combinationally; the back applies it on dequeue.
// A tick holds the back from dequeue through a walk over every controller and a
// final step that marks the last report, plus any output stall.
// The two-entry queue lets the front keep taking requests meanwhile.
// Reset clears all state at once; there is no clearing pass.
// ============================================================================
`default_nettype none

module controller_report_filter_autofire #(
  parameter int NumControllers = crfa_pkg::NUM_CONTROLLERS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crfa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [crfa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  crfa_stream_if.sink                       in_i,
  crfa_stream_if.source                     out_o
);

  crfa_pkg::cfg_t cfg_q, cfg_d;

  crfa_stream_if #(.payload_t(crfa_pkg::qop_t)) front_to_queue ();
  crfa_stream_if #(.payload_t(crfa_pkg::qop_t)) queue_to_back ();

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (crfa_pkg::cfg_reg_e'(cfg_idx_i))
        crfa_pkg::REG_AUTOFIRE_PERIOD:
          cfg_d.autofire_period = cfg_data_i[crfa_pkg::PERIOD_W-1:0];
        crfa_pkg::REG_WATCHDOG_TICKS:
          cfg_d.watchdog_ticks  = cfg_data_i[crfa_pkg::WDOG_W-1:0];
        crfa_pkg::REG_NEUTRAL_HAT:
          cfg_d.neutral_hat     = cfg_data_i[crfa_pkg::HAT_W-1:0];
        crfa_pkg::REG_NEUTRAL_STICK:
          cfg_d.neutral_stick   = cfg_data_i[crfa_pkg::AXIS_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.autofire_period <= crfa_pkg::AUTOFIRE_PERIOD_RST;
      cfg_q.watchdog_ticks  <= crfa_pkg::WATCHDOG_TICKS_RST;
      cfg_q.neutral_hat     <= crfa_pkg::NEUTRAL_HAT_RST;
      cfg_q.neutral_stick   <= crfa_pkg::NEUTRAL_STICK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  crfa_front #(
    .NumControllers(NumControllers)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .op_o   (front_to_queue)
  );

  crfa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_to_queue),
    .pop_o  (queue_to_back)
  );

  crfa_back #(
    .NumControllers(NumControllers)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .op_i   (queue_to_back),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/crfa_checker.sv
// ============================================================================
// crfa_checker - port-level checks of the report filter
// Watches the result channel for reset, stall, range and ordering slips.
// ============================================================================
`default_nettype none

module crfa_checker #(
  parameter int NumControllers = crfa_pkg::NUM_CONTROLLERS
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input crfa_pkg::out_item_t out_data_i
);

  logic                          open_q;
  logic [crfa_pkg::CTRL_W-1:0]   prev_ctrl_q;
  logic                          out_accept;

  assign out_accept = out_valid_i && out_ready_i;

  // Track the controller of the last result of a tick still in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      prev_ctrl_q <= '0;
    end else if (out_accept) begin
      open_q      <= !out_data_i.last_of_tick;
      prev_ctrl_q <= out_data_i.out_controller;
    end
  end

  // No result is offered while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

  // Results name existing controllers (checked for up to four controllers)
  a_ctrl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((NumControllers > 4) || (int'(out_data_i.out_controller) < NumControllers)))
    else $error("result for a controller beyond the count");

  // Within one tick results come in rising controller order (checked for up to four controllers)
  a_tick_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && open_q && (NumControllers <= 4)) |->
      (out_data_i.out_controller > prev_ctrl_q))
    else $error("results of a tick out of controller order");

endmodule

bind controller_report_filter_autofire crfa_checker #(
  .NumControllers(NumControllers)
) u_crfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for the gamepad report filter
// Drives packets and ticks through the request channel, predicts every changed
// report from its own copy of the filter state and checks each one in order.
// Covers sequence filtering, reset packets, autofire, watchdog and stalls.
// ============================================================================

module testbench;
  import crfa_pkg::*;

  localparam int NC            = NUM_CONTROLLERS;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 3000;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  crfa_stream_if #(.payload_t(in_item_t))  req_if ();
  crfa_stream_if #(.payload_t(out_item_t)) rpt_if ();

  controller_report_filter_autofire dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (rpt_if)
  );

  // Idling rates and the hold-off request shared with the receiver
  int send_idle_pct = 14;
  int recv_idle_pct = 45;
  int hold_ticket   = 0;
  int error_count   = 0;
  int report_index  = 0;

  // Shadow of the filter state
  cfg_t                model_cfg;
  report_t             cur_rpt   [NC];
  report_t             sent_rpt  [NC];
  logic [BTN_W-1:0]    act_mask  [NC];
  logic [BTN_W-1:0]    fire_phase[NC];
  logic [PERIOD_W-1:0] toggle_cnt[NC];
  logic [SEQ_W-1:0]    next_exp  [NC];
  logic [WDOG_W-1:0]   silence   [NC];
  bit                  first_due [NC];
  bit                  wd_armed  [NC];
  out_item_t           pending_reports[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Neutral report under the current register values
  function automatic report_t rest_report();
    report_t r;
    r.buttons = '0;
    r.hat     = model_cfg.neutral_hat;
    r.left_x  = model_cfg.neutral_stick;
    r.left_y  = model_cfg.neutral_stick;
    r.right_x = model_cfg.neutral_stick;
    r.right_y = model_cfg.neutral_stick;
    return r;
  endfunction

  function automatic void init_model();
    model_cfg.autofire_period = AUTOFIRE_PERIOD_RST;
    model_cfg.watchdog_ticks  = WATCHDOG_TICKS_RST;
    model_cfg.neutral_hat     = NEUTRAL_HAT_RST;
    model_cfg.neutral_stick   = NEUTRAL_STICK_RST;
    for (int i = 0; i < NC; i++) begin
      cur_rpt[i]         = rest_report();
      sent_rpt[i]        = '0;
      sent_rpt[i].buttons = SENT_RESET_BUTTONS;
      act_mask[i]        = '0;
      fire_phase[i]      = '0;
      toggle_cnt[i]      = '0;
      next_exp[i]        = '0;
      silence[i]         = '0;
      first_due[i]       = 1'b1;
      wd_armed[i]        = 1'b0;
    end
  endfunction

  // Store or drop one packet request
  function automatic void predict_packet(in_item_t it);
    int   c;
    logic jump;
    c    = int'(it.controller);
    jump = (next_exp[c] > it.seq) && ((next_exp[c] - it.seq) > SEQ_JUMP_LIMIT);
    if (c >= NC) return;
    if (!first_due[c] && (it.seq < next_exp[c]) && !it.reset_flag && !jump) return;
    first_due[c] = 1'b0;
    next_exp[c]  = it.seq + 32'd1;
    if (it.reset_flag) begin
      cur_rpt[c]  = rest_report();
      act_mask[c] = '0;
    end else begin
      cur_rpt[c].buttons = it.buttons;
      cur_rpt[c].hat     = it.hat;
      cur_rpt[c].left_x  = it.left_x;
      cur_rpt[c].left_y  = it.left_y;
      cur_rpt[c].right_x = it.right_x;
      cur_rpt[c].right_y = it.right_y;
      act_mask[c] = it.autofire_flag ? it.fire_mask : '0;
    end
    silence[c]  = '0;
    wd_armed[c] = 1'b1;
  endfunction

  // Walk all controllers and queue every changed report
  function automatic void predict_tick();
    logic [PERIOD_W-1:0] period;
    report_t             r;
    out_item_t           found[NC];
    int                  n;
    n      = 0;
    period = (model_cfg.autofire_period == '0) ? PERIOD_W'(1) : model_cfg.autofire_period;
    for (int i = 0; i < NC; i++) begin
      if (wd_armed[i]) begin
        if (silence[i] != 16'hFFFF) silence[i]++;
        if (silence[i] >= model_cfg.watchdog_ticks) begin
          cur_rpt[i]  = rest_report();
          act_mask[i] = '0;
          wd_armed[i] = 1'b0;
          silence[i]  = '0;
        end
      end
      r = cur_rpt[i];
      if (act_mask[i] != '0) begin
        toggle_cnt[i]++;
        if (toggle_cnt[i] >= period) begin
          toggle_cnt[i] = '0;
          fire_phase[i] ^= act_mask[i];
        end
        r.buttons = (r.buttons & ~act_mask[i]) | (fire_phase[i] & act_mask[i]);
      end else begin
        toggle_cnt[i] = '0;
        fire_phase[i] = '0;
      end
      if (r != sent_rpt[i]) begin
        sent_rpt[i]              = r;
        found[n].out_controller  = CTRL_W'(i);
        found[n].out_buttons     = r.buttons;
        found[n].out_hat         = r.hat;
        found[n].out_left_x      = r.left_x;
        found[n].out_left_y      = r.left_y;
        found[n].out_right_x     = r.right_x;
        found[n].out_right_y     = r.right_y;
        found[n].last_of_tick    = 1'b0;
        n++;
      end
    end
    if (n > 0) found[n-1].last_of_tick = 1'b1;
    for (int k = 0; k < n; k++) pending_reports.push_back(found[k]);
  endfunction

  // Predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      if (req_if.data.req_type == REQ_TICK) predict_tick();
      else predict_packet(req_if.data);
    end
  end

  task automatic flag_mismatch(input string what, input out_item_t got,
                               input out_item_t want);
    error_count++;
    $display("report %0d: %s got %h want %h", report_index, what, got, want);
  endtask

  // Compare each delivered report with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && rpt_if.valid && rpt_if.ready) begin
      got = rpt_if.data;
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected report", got, '0);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want)
          flag_mismatch("wrong report", got, want);
      end
      report_index++;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    rpt_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rpt_if.ready <= 1'b0;
      end else begin
        rpt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stall watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    int stall_cycles;
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rpt_if.valid && rpt_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("controller_report_filter_autofire: mismatch");
        $finish;
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Stop offering, wait for every predicted report, then let the block settle
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic set_config(input logic [PERIOD_W-1:0] period,
                            input logic [WDOG_W-1:0] wdog,
                            input logic [HAT_W-1:0] hat,
                            input logic [AXIS_W-1:0] stick);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_AUTOFIRE_PERIOD;
    cfg_data <= CFG_DATA_W'(period);
    @(posedge clk);
    cfg_idx  <= REG_WATCHDOG_TICKS;
    cfg_data <= CFG_DATA_W'(wdog);
    @(posedge clk);
    cfg_idx  <= REG_NEUTRAL_HAT;
    cfg_data <= CFG_DATA_W'(hat);
    @(posedge clk);
    cfg_idx  <= REG_NEUTRAL_STICK;
    cfg_data <= CFG_DATA_W'(stick);
    @(posedge clk);
    cfg_we   <= 1'b0;
    model_cfg.autofire_period = period;
    model_cfg.watchdog_ticks  = wdog;
    model_cfg.neutral_hat     = hat;
    model_cfg.neutral_stick   = stick;
  endtask

  function automatic in_item_t make_packet(input int ctrl, input logic [31:0] seq,
                                           input int rst, input int af,
                                           input logic [15:0] mask,
                                           input logic [15:0] buttons,
                                           input logic [3:0] hat,
                                           input logic [31:0] axes);
    in_item_t it;
    it.req_type      = REQ_PACKET;
    it.controller    = CTRL_W'(ctrl);
    it.seq           = seq;
    it.reset_flag    = (rst != 0);
    it.autofire_flag = (af != 0);
    it.fire_mask     = mask;
    it.buttons       = buttons;
    it.hat           = hat;
    {it.left_x, it.left_y, it.right_x, it.right_y} = axes;
    return it;
  endfunction

  // Tick with random content in the ignored fields
  function automatic in_item_t make_tick();
    in_item_t it;
    it          = make_packet($urandom_range(3), $urandom, $urandom_range(1),
                              $urandom_range(1), 16'($urandom), 16'($urandom),
                              4'($urandom), $urandom);
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // Ticks and mostly in-order packets, with drops, restarts, resets and wild numbers
  function automatic in_item_t random_item();
    int               c;
    int               pick;
    logic [31:0]      seq;
    logic [15:0]      mask;
    int               rst;
    if ($urandom_range(99) < 40) return make_tick();
    c    = $urandom_range(NC - 1);
    pick = $urandom_range(99);
    rst  = 0;
    if (pick < 65)      seq = next_exp[c] + $urandom_range(3);
    else if (pick < 77) seq = next_exp[c] - $urandom_range(1, 100);
    else if (pick < 83) seq = next_exp[c] - $urandom_range(101, 1000);
    else if (pick < 90) begin
      seq = next_exp[c] - $urandom_range(50);
      rst = 1;
    end else seq = $urandom;
    case ($urandom_range(3))
      0:       mask = '0;
      1:       mask = 16'h1 << $urandom_range(15);
      2:       mask = 16'hFFFF;
      default: mask = 16'($urandom);
    endcase
    return make_packet(c, seq, rst, $urandom_range(1), mask, 16'($urandom),
                       4'($urandom), $urandom);
  endfunction

  // After reset every controller differs from the last sent report
  task automatic test_reset_report();
    send_item(make_tick());
  endtask

  // Field extremes and sequence wrap
  task automatic test_packet_extremes();
    send_item(make_packet(0, 32'h0, 0, 0, 16'hFFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
    send_item(make_packet(1, 32'hFFFF_FFFF, 0, 1, 16'h0, 16'h0, 4'h0, 32'h0));
    send_item(make_packet(2, 32'd7, 0, 1, 16'hFFFF, 16'h0, 4'h9, 32'h0102_0304));
    send_item(make_tick());
  endtask

  // Drop old packets, take restarts, resets and first packets
  task automatic test_sequence_filter();
    send_item(make_packet(0, 32'd10, 0, 0, 16'h0, 16'h1111, 4'h1, 32'h1111_1111));
    send_item(make_packet(0, 32'd5, 0, 0, 16'h0, 16'h2222, 4'h2, 32'h2222_2222));
    send_item(make_packet(0, 32'd10, 0, 0, 16'h0, 16'h3333, 4'h3, 32'h3333_3333));
    send_item(make_packet(0, 32'd11, 0, 0, 16'h0, 16'h4444, 4'h4, 32'h4444_4444));
    send_item(make_packet(1, 32'd0, 0, 0, 16'h0, 16'h5555, 4'h5, 32'h5555_5555));
    send_item(make_packet(3, 32'd300, 0, 0, 16'h0, 16'h6666, 4'h6, 32'h6666_6666));
    send_item(make_packet(3, 32'd201, 0, 0, 16'h0, 16'h7777, 4'h7, 32'h7777_7777));
    send_item(make_packet(3, 32'd200, 0, 0, 16'h0, 16'h8888, 4'h8, 32'h8888_8888));
    send_item(make_tick());
    send_item(make_packet(3, 32'd150, 1, 1, 16'hFFFF, 16'h9999, 4'h9, 32'h9999_9999));
    send_item(make_tick());
  endtask

  // Toggle every tick, clear the mask, then a zero period
  task automatic test_autofire();
    set_config(10'd1, 16'd1000, 4'h0, 8'h00);
    send_item(make_packet(0, 32'd12, 0, 1, 16'h00F0, 16'h0F0F, 4'h2, 32'h10203040));
    send_item(make_tick());
    send_item(make_tick());
    send_item(make_packet(0, 32'd13, 0, 0, 16'hFFFF, 16'h0F0F, 4'h2, 32'h10203040));
    send_item(make_tick());
    set_config(10'd0, 16'd1000, 4'h0, 8'h00);
    send_item(make_packet(0, 32'd14, 0, 1, 16'h8001, 16'h0000, 4'h3, 32'h0));
    send_item(make_tick());
    send_item(make_tick());
  endtask

  // Silence timeout, a zero timeout and a reset under new neutral values
  task automatic test_watchdog();
    set_config(10'd1000, 16'd2, 4'hF, 8'hFF);
    send_item(make_packet(1, 32'd1, 0, 0, 16'h0, 16'hA5A5, 4'h6, 32'h5A5A_5A5A));
    send_item(make_tick());
    send_item(make_tick());
    send_item(make_tick());
    set_config(10'd1000, 16'd0, 4'h5, 8'h80);
    send_item(make_packet(2, 32'd8, 0, 1, 16'h00FF, 16'h1234, 4'hA, 32'hDEAD_BEEF));
    send_item(make_tick());
    send_item(make_packet(3, 32'd202, 1, 0, 16'h0, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
    send_item(make_tick());
  endtask

  // Hold the receiver off while ticks keep coming, then pause for the drain
  task automatic test_backpressure();
    set_config(10'd1, 16'hFFFF, 4'hF, 8'hFF);
    for (int c = 0; c < NC; c++)
      send_item(make_packet(c, next_exp[c], 0, 1, 16'hFFFF, 16'($urandom),
                            4'($urandom), $urandom));
    hold_ticket++;
    repeat (16) send_item(make_tick());
    wait_drained();
  endtask

  // Random traffic under one idling pattern and one register setting
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count);
    set_config(PERIOD_W'($urandom_range(1, 4)), WDOG_W'($urandom_range(2, 12)),
               HAT_W'($urandom_range(15)), AXIS_W'($urandom_range(255)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(random_item());
  endtask

  // Sequence the tests
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_AUTOFIRE_PERIOD;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    init_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_report();
    test_packet_extremes();
    test_sequence_filter();
    test_autofire();
    test_watchdog();
    test_backpressure();
    test_random_traffic(14, 45, 56);
    test_random_traffic(45, 14, 56);
    test_random_traffic(0, 0, 56);

    wait_drained();
    if (error_count == 0) begin
      $display("controller_report_filter_autofire: match");
    end else begin
      $display("controller_report_filter_autofire: mismatch");
    end
    $finish;
  end

endmodule
